@@ hdl/b64d_pkg.sv @@
// Types, constants and helper functions shared by the base64 stream decoder.
// No dependencies; every other file of the decoder refers to it by scoped names.
`default_nettype none

package b64d_pkg;

  // One input word: a character of the encoded string and its end flag.
  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_string;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_string;
  } out_word_t;

  // Work handed from the front to the back: up to three bytes, most
  // significant first, how many of them are real, and the end flag.
  // A job with no bytes and the end flag set is an end-only marker.
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  nbytes;
    logic        last;
  } job_t;

  // Result of the alphabet lookup.
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;

  localparam logic [5:0] LowerBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;
  localparam logic [5:0] PlusCode  = 6'd62;
  localparam logic [5:0] SlashCode = 6'd63;

  // Maps a character through the standard alphabet. The pad character and
  // every code outside the alphabet come back as not valid.
  function automatic sextet_t sextet_decode(input logic [7:0] ch);
    sextet_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (ch >= CharUpperA && ch <= CharUpperZ) begin
      d = ch - CharUpperA;
      r.valid = 1'b1;
      r.value = d[5:0];
    end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
      d = ch - CharLowerA;
      r.valid = 1'b1;
      r.value = d[5:0] + LowerBase;
    end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
      d = ch - CharDigit0;
      r.valid = 1'b1;
      r.value = d[5:0] + DigitBase;
    end else if (ch == CharPlus) begin
      r.valid = 1'b1;
      r.value = PlusCode;
    end else if (ch == CharSlash) begin
      r.valid = 1'b1;
      r.value = SlashCode;
    end
    return r;
  endfunction

  // Turns k pending sextets (newest in the low bits) into k-1 bytes.
  // Fewer than two sextets give no byte. The end flag is left clear.
  function automatic job_t flush_job(input logic [17:0] sextets, input logic [1:0] k);
    job_t j;
    j = '0;
    case (k)
      2'd3: begin
        j.bytes  = {sextets, 6'b0};
        j.nbytes = 2'd2;
      end
      2'd2: begin
        j.bytes  = {sextets[11:0], 12'b0};
        j.nbytes = 2'd1;
      end
      default: begin
        j.bytes  = '0;
        j.nbytes = 2'd0;
      end
    endcase
    return j;
  endfunction

endpackage

`default_nettype wire

@@ hdl/b64d_front.sv @@
// Front of the base64 decoder: classifies each accepted character, keeps the
// pending sextets and the stop flag, and forms a job for each character that completes bytes or ends a string.
// Depends on b64d_pkg.
`default_nettype none

module b64d_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire b64d_pkg::in_word_t item,
  input  wire logic              accept,
  output      b64d_pkg::job_t    job,
  output      logic              job_valid
);

  logic [17:0] sextets;
  logic [1:0]  count;
  logic        stopped;

  logic [17:0] sextets_next;
  logic [1:0]  count_next;
  logic        stopped_next;

  b64d_pkg::sextet_t dec;
  logic [17:0]       grown;
  logic [1:0]        grown_count;

  always_comb begin
    dec          = b64d_pkg::sextet_decode(item.in_char);
    grown        = {sextets[11:0], dec.value};
    grown_count  = count + 2'd1;
    sextets_next = sextets;
    count_next   = count;
    stopped_next = stopped;
    job          = '0;

    if (!stopped) begin
      if (dec.valid) begin
        if (count == 2'd3) begin
          // Fourth sextet completes a group of three bytes.
          job.bytes    = {sextets, dec.value};
          job.nbytes   = 2'd3;
          sextets_next = '0;
          count_next   = 2'd0;
        end else begin
          sextets_next = grown;
          count_next   = grown_count;
          if (item.end_of_string) begin
            job = b64d_pkg::flush_job(grown, grown_count);
          end
        end
      end else begin
        // Pad or foreign character: flush what is pending and stop.
        job          = b64d_pkg::flush_job(sextets, count);
        sextets_next = '0;
        count_next   = 2'd0;
        stopped_next = 1'b1;
      end
    end

    job.last = item.end_of_string;
    if (item.end_of_string) begin
      sextets_next = '0;
      count_next   = 2'd0;
      stopped_next = 1'b0;
    end

    job_valid = accept && (job.nbytes != 2'd0 || item.end_of_string);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextets <= '0;
      count   <= '0;
      stopped <= 1'b0;
    end else if (accept) begin
      sextets <= sextets_next;
      count   <= count_next;
      stopped <= stopped_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/b64d_job_queue.sv @@
// Short queue of decoder jobs between the front and the back.
// Depends on b64d_pkg for the job type.
`default_nettype none

module b64d_job_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire b64d_pkg::job_t push_job,
  input  wire logic           push,
  input  wire logic           pop,
  output      b64d_pkg::job_t head,
  output      logic           full,
  output      logic           empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64d_pkg::job_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  logic do_push;
  logic do_pop;

  assign full    = (fill == CntW'(Depth));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/b64d_back.sv @@
// Back of the base64 decoder: walks the bytes of the head job, one per cycle
// while the result is free, into a registered result word. Depends on b64d_pkg.
`default_nettype none

module b64d_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire b64d_pkg::job_t  head,
  input  wire logic            head_empty,
  output      logic            head_pop,
  output      b64d_pkg::out_word_t result,
  output      logic            empty,
  input  wire logic            pop
);

  logic [1:0] idx;
  logic       out_valid;

  logic       load;
  logic       final_byte;
  logic [7:0] sel_byte;

  b64d_pkg::out_word_t next_word;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.bytes[23:16];
      2'd1:    sel_byte = head.bytes[15:8];
      default: sel_byte = head.bytes[7:0];
    endcase
    final_byte = (head.nbytes == 2'd0) || (idx == head.nbytes - 2'd1);
    load       = !head_empty && (!out_valid || pop);
    head_pop   = load && final_byte;

    next_word.has_byte       = (head.nbytes != 2'd0);
    next_word.out_byte       = next_word.has_byte ? sel_byte : 8'h00;
    next_word.last_of_string = head.last && final_byte;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= final_byte ? 2'd0 : idx + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/base64_stream_decoder_core.sv @@
// Top level of the base64 stream decoder: front, job queue and back.
// Depends on b64d_pkg, b64d_front, b64d_job_queue and b64d_back.
`default_nettype none

// Channel   Handshake      Word type             Direction
// item      push / full    b64d_pkg::in_word_t   characters in
// result    pop / empty    b64d_pkg::out_word_t  decoded bytes out
//
// A character is taken in every cycle that the job queue has room; the front
// forms its job in the same cycle. The back emits one result word per cycle
// while the receiver pops, so a full group of four characters gives three
// words at the back, and the JobDepth-entry queue absorbs the bursts.
// Reset (rst, synchronous) clears the pending sextets, the stop flag, the
// queue pointers and the result valid flag; no clearing pass is needed.
// A stalled result side fills the queue and then raises full; the front holds.

module base64_stream_decoder_core #(
  parameter int unsigned JobDepth = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire b64d_pkg::in_word_t  item,
  input  wire logic                push,
  output      logic                full,
  output      b64d_pkg::out_word_t result,
  output      logic                empty,
  input  wire logic                pop
);

  b64d_pkg::job_t job;
  b64d_pkg::job_t head;
  logic           job_valid;
  logic           accept;
  logic           head_empty;
  logic           head_pop;

  // A word is accepted whenever push meets a queue with room.
  assign accept = push && !full;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .accept    (accept),
    .job       (job),
    .job_valid (job_valid)
  );

  b64d_job_queue #(
    .Depth (JobDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_job (job),
    .push     (job_valid),
    .pop      (head_pop),
    .head     (head),
    .full     (full),
    .empty    (head_empty)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for base64_stream_decoder_core: strings of base64
// characters go in one word per push, and decoded bytes are checked as they pop.
// Depends on b64d_pkg for the word types and on the decoder RTL itself.

module testbench;

  // ASCII codes of the alphabet boundaries and of the special characters.
  localparam logic [7:0] UpperFirst = 8'h41;
  localparam logic [7:0] UpperLast  = 8'h5A;
  localparam logic [7:0] LowerFirst = 8'h61;
  localparam logic [7:0] LowerLast  = 8'h7A;
  localparam logic [7:0] DigitFirst = 8'h30;
  localparam logic [7:0] DigitLast  = 8'h39;
  localparam logic [7:0] PlusChar   = 8'h2B;
  localparam logic [7:0] SlashChar  = 8'h2F;
  localparam logic [7:0] PadChar    = 8'h3D;

  // Cycles the decoder may still need after its last expected word, the
  // receiver's long hold-off, and the cycle budget of the whole run.
  localparam int SettleCycles = 12;
  localparam int HoldCycles   = 120;
  localparam int CycleLimit   = 200000;

  // Shapes of generated strings: properly encoded, cut short, or random junk.
  typedef enum {Clean, Truncated, Noise} text_kind_t;

  // Tracks the decoder's state and keeps the decoded words still to come.
  class decode_tracker;
    logic [17:0]         sextets;
    logic [1:0]          held;
    bit                  halted;
    b64d_pkg::out_word_t awaited[$];
    b64d_pkg::out_word_t fresh[$];
    int                  errors;
    int                  checked;

    function new();
      clear_string();
      errors  = 0;
      checked = 0;
    endfunction

    function void clear_string();
      sextets = '0;
      held    = '0;
      halted  = 1'b0;
    endfunction

    function void add_byte(logic [7:0] b);
      b64d_pkg::out_word_t w;
      w.out_byte       = b;
      w.has_byte       = 1'b1;
      w.last_of_string = 1'b0;
      fresh.push_back(w);
    endfunction

    // Pending sextets are left-aligned into a group; missing ones are zero.
    function void flush_held();
      logic [23:0] grp;
      if (held == 2'd3) begin
        grp = {sextets, 6'b0};
        add_byte(grp[23:16]);
        add_byte(grp[15:8]);
      end else if (held == 2'd2) begin
        grp = {sextets[11:0], 12'b0};
        add_byte(grp[23:16]);
      end
    endfunction

    function void take_char(b64d_pkg::in_word_t w);
      logic [7:0]          ch;
      logic [5:0]          v;
      logic [23:0]         grp;
      bit                  known;
      b64d_pkg::out_word_t tail;
      fresh.delete();
      ch    = w.in_char;
      known = 1'b1;
      v     = '0;
      if (ch >= UpperFirst && ch <= UpperLast) v = 6'(ch - UpperFirst);
      else if (ch >= LowerFirst && ch <= LowerLast) v = 6'(ch - LowerFirst + 8'd26);
      else if (ch >= DigitFirst && ch <= DigitLast) v = 6'(ch - DigitFirst + 8'd52);
      else if (ch == PlusChar) v = 6'd62;
      else if (ch == SlashChar) v = 6'd63;
      else known = 1'b0;

      if (!halted) begin
        if (known) begin
          if (held == 2'd3) begin
            grp = {sextets, v};
            add_byte(grp[23:16]);
            add_byte(grp[15:8]);
            add_byte(grp[7:0]);
            sextets = '0;
            held    = '0;
          end else begin
            sextets = {sextets[11:0], v};
            held    = held + 2'd1;
          end
          if (w.end_of_string) flush_held();
        end else begin
          // Pad or foreign character: flush what is pending, ignore the rest.
          flush_held();
          sextets = '0;
          held    = '0;
          halted  = 1'b1;
        end
      end

      if (w.end_of_string) begin
        if (fresh.size() == 0) begin
          tail.out_byte       = 8'h00;
          tail.has_byte       = 1'b0;
          tail.last_of_string = 1'b1;
        end else begin
          tail = fresh.pop_back();
          tail.last_of_string = 1'b1;
        end
        fresh.push_back(tail);
        clear_string();
      end
      foreach (fresh[i]) awaited.push_back(fresh[i]);
    endfunction

    function void check_result(b64d_pkg::out_word_t r);
      b64d_pkg::out_word_t want;
      checked++;
      if (awaited.size() == 0) begin
        $error("unexpected word: out_byte %02h has_byte %0b last_of_string %0b",
               r.out_byte, r.has_byte, r.last_of_string);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (r.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, r.out_byte);
        errors++;
      end
      if (r.has_byte !== want.has_byte) begin
        $error("has_byte: expected %0b, got %0b", want.has_byte, r.has_byte);
        errors++;
      end
      if (r.last_of_string !== want.last_of_string) begin
        $error("last_of_string: expected %0b, got %0b",
               want.last_of_string, r.last_of_string);
        errors++;
      end
    endfunction

    function int awaited_count();
      return awaited.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  b64d_pkg::in_word_t  item;
  logic                push;
  logic                full;
  b64d_pkg::out_word_t result;
  logic                empty;
  logic                pop;

  decode_tracker      tracker;
  b64d_pkg::in_word_t text[$];

  // Idle percentages for each side; the receiver reads its own every cycle.
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;
  int cycles        = 0;
  int chars_taken   = 0;
  int strings_taken = 0;
  int full_stalls   = 0;

  base64_stream_decoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .push   (push),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Monitor. Handshakes are sampled at the rising edge, before any of this
  // edge's nonblocking updates land, so both sides see the same pre-edge
  // values. The result is checked before the input is noted, so a spurious
  // word can never match an expectation created in the same cycle.
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (pop && !empty) tracker.check_result(result);
      if (push && !full) begin
        tracker.take_char(item);
        chars_taken++;
        if (item.end_of_string) strings_taken++;
      end
      if (push && full) full_stalls++;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycles >= CycleLimit);
    $display("testbench: FAIL");
    $finish;
  end

  // Receiver. It pops at random according to rx_idle_pct, and on request it
  // holds off for a long stretch so that the job queue fills and full rises.
  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    pop       = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = HoldCycles - 1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Encoder side of the alphabet, used only to build stimulus strings.
  function automatic logic [7:0] to_char(logic [5:0] v);
    if (v < 6'd26) return UpperFirst + {2'b00, v};
    if (v < 6'd52) return LowerFirst + {2'b00, v - 6'd26};
    if (v < 6'd62) return DigitFirst + {2'b00, v - 6'd52};
    if (v == 6'd62) return PlusChar;
    return SlashChar;
  endfunction

  // Builds one string into text, with the end flag on its last character.
  // Clean strings encode random bytes; the final group of a short tail may
  // carry padding, junk after the padding, and nonzero unused low bits.
  function automatic void fill_text(text_kind_t kind);
    logic [7:0]         chars[$];
    logic [23:0]        grp;
    b64d_pkg::in_word_t w;
    int                 nbytes;
    int                 rem;
    int                 keep;
    int                 pick;
    bit                 pad;
    text.delete();
    if (kind == Noise) begin
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(3);
        if (pick < 2) chars.push_back(to_char(6'($urandom_range(63))));
        else if (pick == 2) chars.push_back(PadChar);
        else chars.push_back(8'($urandom_range(255)));
      end
    end else begin
      nbytes = ($urandom_range(9) == 0) ? $urandom_range(8, 15) : $urandom_range(1, 7);
      pad    = ($urandom_range(3) != 0);
      for (int i = 0; i < nbytes; i += 3) begin
        rem = (nbytes - i > 3) ? 3 : nbytes - i;
        grp = 24'($urandom);
        for (int k = 0; k <= rem; k++) chars.push_back(to_char(grp[23 - 6 * k -: 6]));
        if (rem < 3 && pad) begin
          repeat (3 - rem) chars.push_back(PadChar);
          if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(255)));
        end
      end
      if (kind == Truncated) begin
        keep = $urandom_range(1, chars.size());
        while (chars.size() > keep) void'(chars.pop_back());
      end
    end
    foreach (chars[i]) begin
      w.in_char       = chars[i];
      w.end_of_string = (i == chars.size() - 1);
      text.push_back(w);
    end
  endfunction

  // Offers one word, idling first at the sender's current rate, and returns
  // at the edge where the word is taken. push stays high on return so that a
  // back-to-back word needs only one assignment in the next step.
  task automatic offer(input b64d_pkg::in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    item <= w;
    push <= 1'b1;
    do @(posedge clk); while (full);
  endtask

  task automatic send_chars(input string s, input bit ends);
    b64d_pkg::in_word_t w;
    for (int i = 0; i < s.len(); i++) begin
      w.in_char       = s.getc(i);
      w.end_of_string = ends && (i == s.len() - 1);
      offer(w);
    end
  endtask

  task automatic send_text();
    foreach (text[i]) offer(text[i]);
  endtask

  // Sender pause: nothing is offered until every expected word has popped,
  // then the back end is given a settling time to show anything unexpected.
  task automatic wait_for_results();
    push <= 1'b0;
    do @(posedge clk); while (tracker.awaited_count() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_phase(input int tx, input int rx, input int min_chars);
    int         sent;
    int         pick;
    text_kind_t kind;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    sent        = 0;
    while (sent < min_chars) begin
      pick = $urandom_range(99);
      kind = (pick < 65) ? Clean : (pick < 80) ? Truncated : Noise;
      fill_text(kind);
      send_text();
      sent += text.size();
    end
    wait_for_results();
  endtask

  initial begin
    b64d_pkg::in_word_t w;
    tracker = new();
    rst     = 1'b1;
    push    = 1'b0;
    item    = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed strings under the first idling mix. A full group, groups that
    // use plus, slash and the far ends of each range, an end on a partial
    // group, a stop after two sextets with an ignored end character, double
    // padding, stops on codes 0xFF and 0x00, and a lone sextet at the end,
    // which gives only an end marker.
    tx_idle_pct = 34;
    rx_idle_pct = 82;
    send_chars("TWFu", 1'b1);
    send_chars("+/z0", 1'b0);
    send_chars("9aZ", 1'b1);
    send_chars("AB=x", 1'b1);
    send_chars("TQ==", 1'b1);
    w.in_char       = 8'hFF;
    w.end_of_string = 1'b1;
    offer(w);
    w.in_char       = 8'h00;
    w.end_of_string = 1'b0;
    offer(w);
    send_chars("Q", 1'b1);
    send_chars("Q", 1'b1);
    wait_for_results();

    // Random strings under each idling mix in turn.
    run_phase(34, 82, 14);
    run_phase(82, 34, 14);
    run_phase(0, 0, 14);

    // Back pressure: the receiver stops for a long stretch while clean
    // strings keep coming at full rate, so the job queue fills up.
    hold_requests++;
    tx_idle_pct = 0;
    repeat (5) begin
      fill_text(Clean);
      send_text();
    end
    wait_for_results();

    if (tracker.awaited_count() != 0) begin
      $error("%0d decoded words never arrived", tracker.awaited_count());
      tracker.errors++;
    end
    $display("Run covered %0d strings, %0d characters and %0d decoded words;",
             strings_taken, chars_taken, tracker.checked);
    $display("the sender saw full in %0d cycles and %0d mismatches were found.",
             full_stalls, tracker.errors);
    if (tracker.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_job_queue.sv
hdl/b64d_back.sv
hdl/base64_stream_decoder_core.sv
bench/testbench.sv
